// ===== rtl/core/brsct_pkg.sv =====
// Shared types, command codes and helper functions for the bitmap rectangle core.
`default_nettype none

package brsct_pkg;

    localparam int COORD_BITS = 10;
    localparam int COUNT_BITS = 21;

    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_INVERT = 2'd2;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [COORD_BITS-1:0] left_col;
        logic [COORD_BITS-1:0] top_row;
        logic [COORD_BITS-1:0] right_col;
        logic [COORD_BITS-1:0] bottom_row;
    } t_in;

    typedef struct packed {
        logic [COUNT_BITS-1:0] lit_count;
        logic                  range_error;
    } t_out;

    // Ones in one byte.
    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/brsct_count.sv =====
// Running set-cell count: per-byte popcount of gained and lost bits, then accumulate.
`default_nettype none

module brsct_count #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic [WORD_BITS-1:0]            i_old,
    input  wire logic [WORD_BITS-1:0]            i_new,
    output logic                                 o_busy,
    output logic [brsct_pkg::COUNT_BITS-1:0]     o_total
);
    import brsct_pkg::*;

    localparam int LANES = (WORD_BITS + 7) / 8;
    localparam int PADW  = LANES * 8;

    logic [PADW-1:0]       gain_bits;
    logic [PADW-1:0]       lose_bits;
    logic [3:0]            r_gain [LANES];
    logic [3:0]            r_lose [LANES];
    logic                  r_lane_valid;
    logic [6:0]            gain_sum;
    logic [6:0]            lose_sum;
    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] n_total;

    assign gain_bits = PADW'(i_new & ~i_old);
    assign lose_bits = PADW'(i_old & ~i_new);

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_gain[l] <= pop8(gain_bits[l*8 +: 8]);
            r_lose[l] <= pop8(lose_bits[l*8 +: 8]);
        end
    end

    always_comb begin
        gain_sum = '0;
        lose_sum = '0;
        for (int l = 0; l < LANES; l++) begin
            gain_sum = gain_sum + 7'(r_gain[l]);
            lose_sum = lose_sum + 7'(r_lose[l]);
        end
        n_total = r_total;
        if (r_lane_valid) begin
            n_total = r_total + COUNT_BITS'(gain_sum) - COUNT_BITS'(lose_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_valid <= 1'b0;
            r_total      <= '0;
        end else begin
            r_lane_valid <= i_valid;
            r_total      <= n_total;
        end
    end

    assign o_busy  = r_lane_valid;
    assign o_total = r_total;

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_rect_set_clear_toggle_core.sv =====
// Top level: one-bit grid in a word memory, rectangle set/clear/invert with running count.
//
// Input channel (i_in_valid / o_in_ready / i_in): one command plus an inclusive
// rectangle per transfer. Output channel (o_out_valid / i_out_ready / o_out):
// one result per input item, in order: the count of set cells after the item,
// and a range error flag when a corner lay outside the grid.
//
// Flow: an item that touches cells passes through the decode, split, walk and
// finish states, from its input transfer to the result. The walk does one
// read-modify-write of one memory word per cycle, over rows * words touched
// per row, on the word memory with its separate read and write ports, so the
// walk sets how fast items go through. An item that changes nothing (range
// error, empty rectangle, unused command) goes from decode straight to finish.
// One item is worked on at a time; o_in_ready is high only when idle.
//
// Reset: after reset a clearing pass zeroes the memory, one word a cycle,
// GRID_SIDE*GRID_SIDE/WORD_BITS words (16384 at defaults); no input is taken
// meanwhile. The count register resets to zero.
//
// Stall: the result sits in an output register. While it waits on i_out_ready
// the block already takes and processes the next item; that item's result is
// held back until the register frees up.
`default_nettype none

module bitmap_rect_set_clear_toggle_core #(
    parameter int GRID_SIDE = 1024,
    parameter int WORD_BITS = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire brsct_pkg::t_in  i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output brsct_pkg::t_out      o_out
);
    import brsct_pkg::*;

    localparam int WPR        = GRID_SIDE / WORD_BITS;
    localparam int WORD_COUNT = GRID_SIDE * WPR;
    localparam int AW         = $clog2(WORD_COUNT);
    localparam int BW         = $clog2(WORD_BITS);
    // Reciprocal for column / WORD_BITS; estimate is low by at most one.
    localparam int RSHIFT     = 20;
    localparam int RECIP      = (1 << RSHIFT) / WORD_BITS;
    localparam int PW         = COORD_BITS + RSHIFT;

    localparam logic [AW-1:0]        LAST_WORD = AW'(WORD_COUNT - 1);
    localparam logic [BW-1:0]        TOP_BIT   = BW'(WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] ALL_ONES  = {WORD_BITS{1'b1}};

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_SPLIT  = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    t_in                   r_item;
    logic [PW-1:0]         r_prod0, r_prod1;
    logic [AW-1:0]         r_base, n_base;
    logic [COORD_BITS-1:0] r_w0, n_w0;
    logic [COORD_BITS-1:0] r_w1, n_w1;
    logic [BW-1:0]         r_lo0, n_lo0;
    logic [BW-1:0]         r_hi1, n_hi1;
    logic [COORD_BITS-1:0] r_wi, n_wi;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic                  r_p_valid;
    logic [AW-1:0]         r_p_addr;
    logic [WORD_BITS-1:0]  r_p_mask;
    logic [WORD_BITS-1:0]  r_rd_data;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    logic [WORD_BITS-1:0]  mem [WORD_COUNT];

    logic                  in_xfer;
    logic                  bad;
    logic                  skip;
    logic                  load_out;
    logic [COORD_BITS-1:0] q0_est, q1_est;
    logic [COORD_BITS:0]   rem0, rem1;
    logic [BW-1:0]         lo, hi;
    logic [WORD_BITS-1:0]  iss_mask;
    logic [AW-1:0]         iss_addr;
    logic [WORD_BITS-1:0]  new_word;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [WORD_BITS-1:0]  wdata;
    logic                  cnt_busy;
    logic [COUNT_BITS-1:0] cnt_total;

    assign in_xfer = i_in_valid && o_in_ready;

    // Corner check comes first; then empty rectangle and unused command.
    assign bad  = (int'(r_item.left_col) >= GRID_SIDE) || (int'(r_item.top_row) >= GRID_SIDE) ||
                  (int'(r_item.right_col) >= GRID_SIDE) ||
                  (int'(r_item.bottom_row) >= GRID_SIDE);
    assign skip = bad || (r_item.cmd > CMD_INVERT) ||
                  (r_item.left_col > r_item.right_col) || (r_item.top_row > r_item.bottom_row);

    // Quotient estimate and remainder with one correction step.
    assign q0_est = r_prod0[PW-1 -: COORD_BITS];
    assign q1_est = r_prod1[PW-1 -: COORD_BITS];
    assign rem0   = (COORD_BITS+1)'(r_item.left_col) -
                    (COORD_BITS+1)'((COORD_BITS+1)'(q0_est) * (COORD_BITS+1)'(WORD_BITS));
    assign rem1   = (COORD_BITS+1)'(r_item.right_col) -
                    (COORD_BITS+1)'((COORD_BITS+1)'(q1_est) * (COORD_BITS+1)'(WORD_BITS));

    // Edge words get partial masks.
    assign lo       = (r_wi == r_w0) ? r_lo0 : '0;
    assign hi       = (r_wi == r_w1) ? r_hi1 : TOP_BIT;
    assign iss_mask = (ALL_ONES << lo) & (ALL_ONES >> (TOP_BIT - hi));
    assign iss_addr = r_base + AW'(r_wi);

    always_comb begin
        case (r_item.cmd)
            CMD_SET:   new_word = r_rd_data | r_p_mask;
            CMD_CLEAR: new_word = r_rd_data & ~r_p_mask;
            default:   new_word = r_rd_data ^ r_p_mask;
        endcase
    end

    assign load_out = (r_state == ST_FINISH) && !r_p_valid && !cnt_busy &&
                      (!r_out_valid || i_out_ready);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_base     = r_base;
        n_w0       = r_w0;
        n_w1       = r_w1;
        n_lo0      = r_lo0;
        n_hi1      = r_hi1;
        n_wi       = r_wi;
        n_row      = r_row;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_base  = AW'(int'(r_item.top_row) * WPR);
                n_state = skip ? ST_FINISH : ST_SPLIT;
            end
            ST_SPLIT: begin
                if (rem0 >= (COORD_BITS+1)'(WORD_BITS)) begin
                    n_w0  = q0_est + 1'b1;
                    n_lo0 = BW'(rem0 - (COORD_BITS+1)'(WORD_BITS));
                end else begin
                    n_w0  = q0_est;
                    n_lo0 = BW'(rem0);
                end
                if (rem1 >= (COORD_BITS+1)'(WORD_BITS)) begin
                    n_w1  = q1_est + 1'b1;
                    n_hi1 = BW'(rem1 - (COORD_BITS+1)'(WORD_BITS));
                end else begin
                    n_w1  = q1_est;
                    n_hi1 = BW'(rem1);
                end
                n_wi    = n_w0;
                n_row   = r_item.top_row;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (r_wi == r_w1) begin
                    if (r_row == r_item.bottom_row) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_row  = r_row + 1'b1;
                        n_base = r_base + AW'(WPR);
                        n_wi   = r_w0;
                    end
                end else begin
                    n_wi = r_wi + 1'b1;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (load_out) begin
            n_out_valid       = 1'b1;
            n_out.lit_count   = cnt_total;
            n_out.range_error = bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_p_valid   <= (r_state == ST_WALK);
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in;
        end
        r_prod0  <= PW'(r_item.left_col) * PW'(RECIP);
        r_prod1  <= PW'(r_item.right_col) * PW'(RECIP);
        r_base   <= n_base;
        r_w0     <= n_w0;
        r_w1     <= n_w1;
        r_lo0    <= n_lo0;
        r_hi1    <= n_hi1;
        r_wi     <= n_wi;
        r_row    <= n_row;
        r_p_addr <= iss_addr;
        r_p_mask <= iss_mask;
        r_out    <= n_out;
    end

    // Word memory: clearing pass and write-back share the write port.
    assign we    = (r_state == ST_CLEAR) || r_p_valid;
    assign waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_p_addr;
    assign wdata = (r_state == ST_CLEAR) ? '0 : new_word;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (r_state == ST_WALK) begin
            r_rd_data <= mem[iss_addr];
        end
    end

    brsct_count #(
        .WORD_BITS (WORD_BITS)
    ) u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_valid),
        .i_old   (r_rd_data),
        .i_new   (new_word),
        .o_busy  (cnt_busy),
        .o_total (cnt_total)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/brsct_checker.sv =====
// Port-level checks on the bitmap rectangle core, bound to the top level.
`default_nettype none

module brsct_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_ready,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire brsct_pkg::t_out o_out
);
    import brsct_pkg::*;

    logic                  r_have_last;
    logic [COUNT_BITS-1:0] r_last_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_have_last <= 1'b1;
        end
        if (o_out_valid && i_out_ready) begin
            r_last_cnt <= o_out.lit_count;
        end
    end

    // Clearing pass blocks input right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_ready)
        else $error("input ready during clearing pass");

    a_no_result_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // One item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while first in work");

    // A range error leaves the count where the previous result had it.
    a_err_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out.range_error && r_have_last)
        |-> (o_out.lit_count == r_last_cnt))
        else $error("range error changed the count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind bitmap_rect_set_clear_toggle_core brsct_checker u_brsct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire

// ===== verif/bitmap_rect_set_clear_toggle_core_tb.sv =====
// Self-checking testbench for the bitmap rectangle set/clear/invert core.
`default_nettype none

module bitmap_rect_set_clear_toggle_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brsct_pkg::*;

    // Grid geometry at the block's default parameters.
    localparam int SIDE      = 1024;
    localparam int WBITS     = 64;
    localparam int ROW_WORDS = SIDE / WBITS;
    localparam int WORDS     = SIDE * ROW_WORDS;

    // Code 3 is not a command; the block must leave the grid alone.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Cycles without any transfer on either channel before the run is called hung.
    // Slowest gap: the reset clearing pass or a full-grid walk plus a receiver
    // hold-off; this is several times that.
    localparam int STALL_LIMIT = 100000;

    localparam int HOLD_OFF_CYCLES = 400;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_ready;
    t_in     i_in;
    logic    o_out_valid;
    logic    i_out_ready;
    t_out    o_out;

    bitmap_rect_set_clear_toggle_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // 12 ns clock.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Shadow copy of the grid and its running count.
    logic [WBITS-1:0]      shadow_grid [WORDS];
    logic [COUNT_BITS-1:0] shadow_lit;

    t_out expected_q[$];
    int   err_cnt;

    // Random idling controls; both cleared for the final stretch of the run.
    bit send_gaps;
    bit ready_stalls;
    int hold_off_len;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d (t=%0t)", what, got, want, $realtime);
        err_cnt++;
    endtask

    // Apply one command to the shadow grid and return the result it should give.
    function automatic t_out predict_rect(input t_in item);
        t_out             res;
        int               c0, r0, c1, r1;
        int               w0, w1, lo, hi, at;
        logic [WBITS-1:0] m, old_w, new_w;
        int               lit;
        bit               off_grid;

        c0 = item.left_col;
        r0 = item.top_row;
        c1 = item.right_col;
        r1 = item.bottom_row;
        // With 10-bit corners and a 1024 grid this cannot fire, but keep the rule.
        off_grid = (c0 >= SIDE) || (r0 >= SIDE) || (c1 >= SIDE) || (r1 >= SIDE);

        if (!off_grid && item.cmd != CMD_UNUSED && c0 <= c1 && r0 <= r1) begin
            w0  = c0 / WBITS;
            w1  = c1 / WBITS;
            lit = shadow_lit;
            for (int row = r0; row <= r1; row++) begin
                for (int wi = w0; wi <= w1; wi++) begin
                    lo    = (wi == w0) ? c0 % WBITS : 0;
                    hi    = (wi == w1) ? c1 % WBITS : WBITS - 1;
                    m     = ({WBITS{1'b1}} >> (WBITS - 1 - (hi - lo))) << lo;
                    at    = row * ROW_WORDS + wi;
                    old_w = shadow_grid[at];
                    case (item.cmd)
                        CMD_SET:   new_w = old_w | m;
                        CMD_CLEAR: new_w = old_w & ~m;
                        default:   new_w = old_w ^ m;
                    endcase
                    shadow_grid[at] = new_w;
                    lit = lit - $countones(old_w) + $countones(new_w);
                end
            end
            shadow_lit = COUNT_BITS'(lit);
        end

        res.lit_count   = shadow_lit;
        res.range_error = off_grid;
        return res;
    endfunction

    function automatic t_in rect(input logic [1:0] cmd, input int c0, input int r0,
                                 input int c1, input int r1);
        t_in item;
        item.cmd        = cmd;
        item.left_col   = COORD_BITS'(c0);
        item.top_row    = COORD_BITS'(r0);
        item.right_col  = COORD_BITS'(c1);
        item.bottom_row = COORD_BITS'(r1);
        return item;
    endfunction

    // Mostly small well-formed rectangles anywhere on the grid, some full-width
    // strips, and a little noise (empty rectangles, unused command).
    function automatic t_in random_rect();
        int kind, a, b, c, d;
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            // empty: corners swapped on one axis
            a = $urandom_range(1, SIDE - 1);
            b = $urandom_range(0, a - 1);
            c = $urandom_range(0, SIDE - 1);
            d = $urandom_range(0, SIDE - 1);
            if ($urandom_range(0, 1) == 0)
                return rect(2'($urandom_range(0, 3)), a, c, b, d);
            return rect(2'($urandom_range(0, 3)), c, a, d, b);
        end
        if (kind < 9) begin
            return rect(CMD_UNUSED, $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                        $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1));
        end
        if (kind < 15) begin
            a = $urandom_range(0, SIDE - 33);
            return rect(2'($urandom_range(0, 2)), 0, a, SIDE - 1, a + $urandom_range(0, 31));
        end
        a = $urandom_range(0, SIDE - 1);
        b = a + $urandom_range(0, 150);
        c = $urandom_range(0, SIDE - 1);
        d = c + $urandom_range(0, 40);
        if (b > SIDE - 1) b = SIDE - 1;
        if (d > SIDE - 1) d = SIDE - 1;
        return rect(2'($urandom_range(0, 2)), a, c, b, d);
    endfunction

    // Offer one item; returns at the falling edge after its transfer with valid
    // still high, so a following item can go out back to back.
    task automatic send_rect(input t_in item);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        expected_q.push_back(predict_rect(item));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Whole-grid set, clear and invert: count hits 2^20 and returns to zero.
    task automatic test_full_grid;
        send_rect(rect(CMD_SET, 0, 0, SIDE - 1, SIDE - 1));
        send_rect(rect(CMD_CLEAR, 0, 0, SIDE - 1, SIDE - 1));
        send_rect(rect(CMD_INVERT, 0, 0, SIDE - 1, SIDE - 1));
        send_rect(rect(CMD_INVERT, 0, 0, SIDE - 1, SIDE - 1));
        drain_results();
    endtask

    // One cell at each corner of the grid.
    task automatic test_corner_cells;
        send_rect(rect(CMD_SET, 0, 0, 0, 0));
        send_rect(rect(CMD_SET, SIDE - 1, SIDE - 1, SIDE - 1, SIDE - 1));
        send_rect(rect(CMD_INVERT, SIDE - 1, 0, SIDE - 1, 0));
        send_rect(rect(CMD_SET, 0, SIDE - 1, 0, SIDE - 1));
        drain_results();
    endtask

    // Spans that straddle a word boundary or sit inside one word.
    task automatic test_word_edges;
        send_rect(rect(CMD_SET, 63, 5, 64, 6));
        send_rect(rect(CMD_INVERT, 1, 5, 62, 5));
        send_rect(rect(CMD_INVERT, 60, 4, 130, 7));
        send_rect(rect(CMD_CLEAR, 0, 5, SIDE - 1, 5));
        drain_results();
    endtask

    // Items that must leave the grid untouched.
    task automatic test_no_change;
        send_rect(rect(CMD_SET, 700, 10, 699, 20));
        send_rect(rect(CMD_INVERT, 10, 900, 20, 899));
        send_rect(rect(CMD_SET, SIDE - 1, SIDE - 1, 0, 0));
        send_rect(rect(CMD_UNUSED, 0, 0, SIDE - 1, SIDE - 1));
        drain_results();
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) send_rect(random_rect());
        drain_results();
    endtask

    // Receiver holds off long enough that one result sits in the output
    // register, the next item finishes behind it and the input stalls.
    // Small rectangles keep each walk far shorter than the hold-off.
    task automatic test_backpressure;
        int c, r;
        hold_off_len = HOLD_OFF_CYCLES;
        repeat (6) begin
            c = $urandom_range(0, 900);
            r = $urandom_range(0, 1000);
            send_rect(rect(2'($urandom_range(0, 2)), c, r, c + $urandom_range(0, 63),
                           r + $urandom_range(0, 7)));
        end
        drain_results();
    endtask

    // Receiver: random ready bursts, plus the long hold-off on request.
    initial begin
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_len > 0) begin
                i_out_ready <= 1'b0;
                for (n = 0; n < hold_off_len; n++) @(negedge i_clk);
                hold_off_len = 0;
            end else if (ready_stalls && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each output transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, lit_count", o_out.lit_count, -1);
            end else begin
                want = expected_q.pop_front();
                if (o_out.lit_count !== want.lit_count)
                    report_mismatch("lit_count", o_out.lit_count, want.lit_count);
                if (o_out.range_error !== want.range_error)
                    report_mismatch("range_error", o_out.range_error, want.range_error);
            end
        end
    end

    // Hang detector: cycles in a row with no transfer on either side.
    always @(posedge i_clk) begin
        static int quiet_cycles = 0;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[bitmap_rect_set_clear_toggle_core] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        err_cnt      = 0;
        hold_off_len = 0;
        send_gaps    = 1'b1;
        ready_stalls = 1'b1;
        for (int i = 0; i < WORDS; i++) shadow_grid[i] = '0;
        shadow_lit = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The block runs its clearing pass here; sends wait on o_in_ready.
        test_full_grid();
        test_corner_cells();
        test_word_edges();
        test_no_change();
        test_random_mix(60);
        test_backpressure();

        // Last stretch with no idling on either side.
        send_gaps    = 1'b0;
        ready_stalls = 1'b0;
        test_random_mix(20);

        repeat (30) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("[bitmap_rect_set_clear_toggle_core] OK");
        end else begin
            $display("[bitmap_rect_set_clear_toggle_core] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/brsct_pkg.sv
rtl/core/brsct_count.sv
rtl/core/bitmap_rect_set_clear_toggle_core.sv
rtl/core/brsct_checker.sv
verif/bitmap_rect_set_clear_toggle_core_tb.sv
